FILE: rtl/irps_pkg.sv
package irps_pkg;

    localparam int unsigned SEC_W   = 32;
    localparam int unsigned USEC_W  = 20;
    localparam int unsigned DUR_W   = 24;
    localparam int unsigned GAP_W   = 6;
    localparam int unsigned CFG_W   = 24;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [DUR_W-1:0] DUR_MAX      = {DUR_W{1'b1}};
    localparam int unsigned      USEC_PER_SEC = 1000000;

    // command codes
    localparam logic CMD_EDGE  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GLITCH_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPACE_LIMIT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_SECONDS  = 2'd3;

    // register reset values
    localparam logic             RST_ACTIVE_LOW   = 1'b0;
    localparam logic [DUR_W-1:0] RST_GLITCH_LIMIT = 24'd250;
    localparam logic [DUR_W-1:0] RST_SPACE_LIMIT  = 24'd20000;
    localparam logic [GAP_W-1:0] RST_GAP_SECONDS  = 6'd15;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic             active_low;
        logic [DUR_W-1:0] glitch_limit;
        logic [DUR_W-1:0] space_limit;
        logic [GAP_W-1:0] gap_seconds;
    } t_cfg;

    // classified item handed from front to back
    typedef struct packed {
        logic             cmd;
        logic [DUR_W-1:0] data;
        logic             pulse;
    } t_item;

    typedef struct packed {
        logic [DUR_W-1:0] duration;
        logic             pulse;
        logic             last;
    } t_word;

endpackage

FILE: rtl/irps_front.sv
module irps_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  irps_pkg::t_cfg     i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_cmd,
    input  logic               i_level,
    input  logic [31:0]        i_time_sec,
    input  logic [19:0]        i_time_usec,
    input  logic               i_q_full,
    output logic               o_q_push,
    output irps_pkg::t_item    o_q_item
);
    import irps_pkg::*;

    localparam int unsigned MUL_W = 26;
    localparam int unsigned SUM_W = MUL_W + 1;

    // stage 1: timestamp compare against the previous edge
    logic               r_s1_valid;
    logic               r_s1_cmd;
    logic               r_s1_level;
    logic               r_s1_back;
    logic               r_s1_gap;
    logic [GAP_W-1:0]   r_s1_secd;
    logic [USEC_W-1:0]  r_s1_usec;
    logic [USEC_W-1:0]  r_s1_pusec;
    logic [SEC_W-1:0]   r_prev_sec;
    logic [USEC_W-1:0]  r_prev_usec;

    // stage 2: duration and pulse/space
    logic               r_s2_valid;
    t_item              r_s2_item;
    logic               r_polarity;

    logic               s2_move;
    logic               s1_move;
    logic               in_xfer;
    logic [SEC_W-1:0]   sec_diff;
    logic               back_c;
    logic               gap_c;
    logic [MUL_W-1:0]   prod;
    logic [SUM_W-1:0]   sum;
    logic [SUM_W-1:0]   diff;
    logic [DUR_W-1:0]   n_data;
    logic               n_polarity;
    logic               n_pulse;

    assign o_q_push = r_s2_valid && !i_q_full;
    assign o_q_item = r_s2_item;
    assign s2_move  = !r_s2_valid || o_q_push;
    assign s1_move  = r_s1_valid && s2_move;
    assign o_ready  = !r_s1_valid || s2_move;
    assign in_xfer  = i_valid && o_ready;

    assign sec_diff = i_time_sec - r_prev_sec;
    assign back_c   = (i_time_sec < r_prev_sec) ||
                      ((i_time_sec == r_prev_sec) && (i_time_usec < r_prev_usec));
    assign gap_c    = sec_diff > {{(SEC_W-GAP_W){1'b0}}, i_cfg.gap_seconds};

    assign prod = {{(MUL_W-GAP_W){1'b0}}, r_s1_secd} * MUL_W'(USEC_PER_SEC);
    assign sum  = {1'b0, prod} + {{(SUM_W-USEC_W){1'b0}}, r_s1_usec};
    assign diff = sum - {{(SUM_W-USEC_W){1'b0}}, r_s1_pusec};

    always_comb begin
        n_polarity = r_polarity;
        if (r_s1_cmd == CMD_START) begin
            n_polarity = i_cfg.active_low;
            n_data     = '0;
        end else if (r_s1_back) begin
            n_data = DUR_MAX;
        end else if (r_s1_gap) begin
            n_data = DUR_MAX;
            // a long gap at pulse level means the polarity was wrong
            if (r_s1_level == r_polarity) begin
                n_polarity = !r_polarity;
            end
        end else if (sum < {{(SUM_W-USEC_W){1'b0}}, r_s1_pusec}) begin
            n_data = '0;
        end else if (diff > {{(SUM_W-DUR_W){1'b0}}, DUR_MAX}) begin
            n_data = DUR_MAX;
        end else begin
            n_data = diff[DUR_W-1:0];
        end
        n_pulse = (r_s1_level == n_polarity);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_prev_sec  <= '0;
            r_prev_usec <= '0;
            r_polarity  <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_s1_valid  <= 1'b1;
                r_prev_sec  <= i_time_sec;
                r_prev_usec <= i_time_usec;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_s2_valid <= 1'b1;
                r_polarity <= n_polarity;
            end else if (o_q_push) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_cmd   <= i_cmd;
            r_s1_level <= i_level;
            r_s1_back  <= back_c;
            r_s1_gap   <= gap_c;
            r_s1_secd  <= sec_diff[GAP_W-1:0];
            r_s1_usec  <= i_time_usec;
            r_s1_pusec <= r_prev_usec;
        end
        if (s1_move) begin
            r_s2_item.cmd   <= r_s1_cmd;
            r_s2_item.data  <= n_data;
            r_s2_item.pulse <= n_pulse;
        end
    end

endmodule

FILE: rtl/irps_queue.sv
module irps_queue #(
    parameter int unsigned DEPTH = irps_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  irps_pkg::t_item  i_item,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output irps_pkg::t_item  o_item
);
    import irps_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_item           r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

FILE: rtl/irps_back.sv
module irps_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  irps_pkg::t_cfg   i_cfg,
    input  logic             i_q_valid,
    input  irps_pkg::t_item  i_q_item,
    output logic             o_q_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output irps_pkg::t_word  o_word
);
    import irps_pkg::*;

    function automatic logic [DUR_W-1:0] sat_add(input logic [DUR_W-1:0] a,
                                                  input logic [DUR_W-1:0] b);
        logic [DUR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DUR_W] ? DUR_MAX : s[DUR_W-1:0];
    endfunction

    // filter state
    logic              r_holding;
    logic [DUR_W-1:0]  r_held_space;
    logic [DUR_W-1:0]  r_held_pulse;

    // pending result words, head at slot 0
    t_word             r_w [3];
    logic [1:0]        r_cnt;
    t_word             r_out;
    logic              r_out_valid;

    logic              move;
    logic [1:0]        cnt_after;
    logic              n_holding;
    logic [DUR_W-1:0]  n_held_space;
    logic [DUR_W-1:0]  n_held_pulse;
    logic [DUR_W-1:0]  hp_sum;
    logic [DUR_W-1:0]  hs_sum;
    logic [1:0]        n_words;
    t_word             nw [3];

    assign move      = (r_cnt != 2'd0) && (!r_out_valid || i_ready);
    assign cnt_after = r_cnt - {1'b0, move};
    assign o_q_pop   = i_q_valid && (cnt_after == 2'd0);
    assign o_valid   = r_out_valid;
    assign o_word    = r_out;

    assign hp_sum = sat_add(r_held_pulse, i_q_item.data);
    assign hs_sum = sat_add(sat_add(r_held_space, r_held_pulse), i_q_item.data);

    always_comb begin
        n_holding    = r_holding;
        n_held_space = r_held_space;
        n_held_pulse = r_held_pulse;
        n_words      = 2'd0;
        nw[0]        = '{duration: r_held_space, pulse: 1'b0, last: 1'b0};
        nw[1]        = '{duration: r_held_pulse, pulse: 1'b1, last: 1'b0};
        nw[2]        = '{duration: i_q_item.data, pulse: i_q_item.pulse, last: 1'b1};
        if (i_q_item.cmd == CMD_START) begin
            n_holding    = 1'b0;
            n_held_space = '0;
            n_held_pulse = '0;
        end else if (r_holding && i_q_item.pulse) begin
            // glitch pulse merges until enough pulse time gathers
            if (hp_sum > i_cfg.glitch_limit) begin
                nw[1].duration = hp_sum;
                nw[1].last     = 1'b1;
                n_words        = 2'd2;
                n_holding      = 1'b0;
                n_held_pulse   = '0;
            end else begin
                n_held_pulse = hp_sum;
            end
        end else if (!i_q_item.pulse && (i_q_item.data > i_cfg.space_limit)) begin
            if (!r_holding) begin
                n_held_space = i_q_item.data;
                n_holding    = 1'b1;
            end else begin
                n_held_space = hs_sum;
                n_held_pulse = '0;
            end
        end else if (!i_q_item.pulse && r_holding) begin
            n_words      = 2'd3;
            n_holding    = 1'b0;
            n_held_pulse = '0;
        end else begin
            nw[0]   = nw[2];
            n_words = 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holding    <= 1'b0;
            r_held_space <= '0;
            r_held_pulse <= '0;
            r_cnt        <= 2'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_holding    <= n_holding;
                r_held_space <= n_held_space;
                r_held_pulse <= n_held_pulse;
                r_cnt        <= n_words;
            end else begin
                r_cnt <= cnt_after;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out <= r_w[0];
        end
        if (o_q_pop) begin
            r_w[0] <= nw[0];
            r_w[1] <= nw[1];
            r_w[2] <= nw[2];
        end else if (move) begin
            r_w[0] <= r_w[1];
            r_w[1] <= r_w[2];
        end
    end

endmodule

FILE: rtl/ir_edge_pulse_space_recorder_unit.sv
// IR edge pulse/space recorder with glitch filter.
// Input channel (i_valid/o_ready): one transfer per receiver edge with its
// level and seconds/microseconds timestamp, or a start command that loads
// the timestamp and polarity and clears the filter.
// Output channel (o_valid/i_ready): 24-bit duration words marked pulse or
// space; o_last flags the final word caused by one input transfer. An edge
// gives zero to three words; a start gives none.
// Configuration: i_cfg_we writes register i_cfg_index with i_cfg_data in
// the same cycle; write only while the block is idle.
// Path: front stages 1 and 2, the queue, pending words, output register.
// Throughput: the front takes one edge per cycle while the queue has room;
// the back drains one word per cycle unless the receiver stalls, and pops
// the next item as the last word pending moves out. A queue of QUEUE_DEPTH
// items lets edges keep coming while words wait. When the receiver stalls,
// the output register holds its word, the pending words and queue fill, and
// o_ready drops once the queue and both front stages are full.
// Reset clears timestamps, polarity, filter state and all valid flags, and
// loads the register defaults.
module ir_edge_pulse_space_recorder_unit #(
    parameter int unsigned QUEUE_DEPTH = irps_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [irps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [irps_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_cmd,
    input  logic                          i_level,
    input  logic [31:0]                   i_time_sec,
    input  logic [19:0]                   i_time_usec,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [23:0]                   o_duration_us,
    output logic                          o_is_pulse,
    output logic                          o_last
);
    import irps_pkg::*;

    t_cfg   r_cfg;
    logic   q_full;
    logic   q_push;
    t_item  q_in;
    logic   q_pop;
    logic   q_valid;
    t_item  q_out;
    t_word  word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_low   <= RST_ACTIVE_LOW;
            r_cfg.glitch_limit <= RST_GLITCH_LIMIT;
            r_cfg.space_limit  <= RST_SPACE_LIMIT;
            r_cfg.gap_seconds  <= RST_GAP_SECONDS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ACTIVE_LOW:   r_cfg.active_low   <= i_cfg_data[0];
                REG_GLITCH_LIMIT: r_cfg.glitch_limit <= i_cfg_data[DUR_W-1:0];
                REG_SPACE_LIMIT:  r_cfg.space_limit  <= i_cfg_data[DUR_W-1:0];
                REG_GAP_SECONDS:  r_cfg.gap_seconds  <= i_cfg_data[GAP_W-1:0];
                default:          r_cfg <= r_cfg;
            endcase
        end
    end

    irps_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cmd       (i_cmd),
        .i_level     (i_level),
        .i_time_sec  (i_time_sec),
        .i_time_usec (i_time_usec),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_item    (q_in)
    );

    irps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_out)
    );

    irps_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_item  (q_out),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_word    (word)
    );

    assign o_duration_us = word.duration;
    assign o_is_pulse    = word.pulse;
    assign o_last        = word.last;

endmodule
